// ===== src/kfsd_pkg.sv =====
// Shared types, codes and key helpers for the keyed search-and-delete queue.
package kfsd_pkg;

    // Key geometry: two halves of seven characters each
    localparam int HALF_CHARS = 7;
    localparam int KEY_BYTES  = 2 * HALF_CHARS;
    localparam int HALF_W     = 8 * HALF_CHARS;
    localparam int KEY_W      = 2 * HALF_W;
    localparam int KEY_CHARS  = 14;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [1:0]       func_t;
    typedef logic [1:0]       status_t;

    // Operation codes
    localparam func_t FN_INSERT = 2'd0;
    localparam func_t FN_DELETE = 2'd1;
    localparam func_t FN_SEARCH = 2'd2;
    localparam func_t FN_DUMP   = 2'd3;

    // Result status codes
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NOTFOUND = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_EMPTY    = 2'd3;

    // Zero every character from the first zero character on, and beyond KEY_CHARS.
    // Layout: key_hi in bits [55:0], key_lo in bits [111:56], first char in top byte.
    function automatic key_t normalize_key(input key_t d);
        key_t       r;
        logic       ended;
        logic [7:0] c;
        r     = '0;
        ended = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (i < HALF_CHARS) begin
                c = d[8*(HALF_CHARS-1-i) +: 8];
            end else begin
                c = d[HALF_W + 8*(KEY_BYTES-1-i) +: 8];
            end
            if (i >= KEY_CHARS || c == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                if (i < HALF_CHARS) begin
                    r[8*(HALF_CHARS-1-i) +: 8] = c;
                end else begin
                    r[HALF_W + 8*(KEY_BYTES-1-i) +: 8] = c;
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== src/keyed_fifo_search_delete.sv =====
// Ordered key queue with insert, delete-first-match, search and dump.
//
//  channel  | direction | tdata                               | tuser       | tlast
//  ---------+-----------+-------------------------------------+-------------+-----------
//  s_       | in        | [55:0] key_hi, [111:56] key_lo      | [1:0] func  | -
//  m_       | out       | [55:0] entry_hi, [111:56] entry_lo  | [1:0] status| last
//
// Search and delete walk the store one entry per cycle through the single RAM
// read port and the one 112-bit comparator; a delete then shifts the tail down
// one entry per cycle. Dump emits one entry per cycle while m_tready stays high.
// Reset clears the state, occupancy, pending flag and m_tvalid; entries at or
// above occupancy are never read. A stalled m_ side holds the sequencer whenever
// it has a result to emit; s_tready is high only between requests.
module keyed_fifo_search_delete #(
    parameter int DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [111:0]          s_tdata,   // [55:0] key_hi, [111:56] key_lo
    input  logic [1:0]            s_tuser,   // [1:0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [111:0]          m_tdata,   // [55:0] entry_hi, [111:56] entry_lo
    output logic [1:0]            m_tuser,   // [1:0] status
    output logic                  m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_HIT   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DUMP  = 3'd5;

    logic [2:0]              state_reg, state_next;
    kfsd_pkg::func_t         func_reg, func_next;
    kfsd_pkg::key_t          key_reg, key_next;
    logic [OW-1:0]           occ_reg, occ_next;
    logic [OW-1:0]           idx_reg, idx_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic                    pend_reg, pend_next;

    logic                    m_valid_reg;
    kfsd_pkg::status_t       m_status_reg;
    kfsd_pkg::key_t          m_data_reg;
    logic                    m_last_reg;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    kfsd_pkg::key_t          ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    kfsd_pkg::key_t          ram_rdata;

    logic                    emit;
    kfsd_pkg::status_t       emit_status;
    kfsd_pkg::key_t          emit_data;
    logic                    emit_last;

    logic                    out_free;
    logic                    more;
    logic                    can_emit;
    logic                    issue;

    kfsd_ram #(
        .WIDTH (kfsd_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign more     = idx_reg < occ_reg;
    assign can_emit = pend_reg && out_free;
    assign issue    = more && (!pend_reg || can_emit);
    assign s_tready = (state_reg == S_IDLE);

    // Sequence one request over the store
    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        occ_next    = occ_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        ram_we      = 1'b0;
        ram_waddr   = occ_reg[AW-1:0];
        ram_wdata   = key_reg;
        ram_re      = 1'b0;
        ram_raddr   = idx_reg[AW-1:0];
        emit        = 1'b0;
        emit_status = kfsd_pkg::ST_OK;
        emit_data   = '0;
        emit_last   = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next = s_tuser;
                    key_next  = kfsd_pkg::normalize_key(s_tdata);
                    idx_next  = '0;
                    pend_next = 1'b0;
                    unique case (s_tuser)
                        kfsd_pkg::FN_INSERT: state_next = S_INS;
                        kfsd_pkg::FN_DELETE: state_next = S_SCAN;
                        kfsd_pkg::FN_SEARCH: state_next = S_SCAN;
                        kfsd_pkg::FN_DUMP:   state_next = S_DUMP;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end

            // Append at the tail, or report full
            S_INS: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (occ_reg == OW'(DEPTH)) begin
                        emit_status = kfsd_pkg::ST_FULL;
                    end else begin
                        ram_we   = 1'b1;
                        occ_next = occ_reg + OW'(1);
                    end
                end
            end

            // Read one entry per cycle and compare the one before it
            S_SCAN: begin
                if (pend_reg && ram_rdata == key_reg) begin
                    pend_next  = 1'b0;
                    state_next = S_HIT;
                end else if (more) begin
                    ram_re    = 1'b1;
                    pos_next  = idx_reg[AW-1:0];
                    idx_next  = idx_reg + OW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = kfsd_pkg::ST_NOTFOUND;
                        state_next  = S_IDLE;
                    end
                end
            end

            // Report the match; a delete then closes the gap
            S_HIT: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_data = ram_rdata;
                    if (func_reg == kfsd_pkg::FN_DELETE) begin
                        idx_next   = OW'(pos_reg) + OW'(1);
                        pend_next  = 1'b0;
                        state_next = S_SHIFT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            // Move each later entry down one slot
            S_SHIFT: begin
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (more) begin
                    ram_re    = 1'b1;
                    pos_next  = idx_reg[AW-1:0];
                    idx_next  = idx_reg + OW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    occ_next   = occ_reg - OW'(1);
                    state_next = S_IDLE;
                end
            end

            // Stream every entry from head to tail, or report an empty queue
            S_DUMP: begin
                if (occ_reg == '0) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = kfsd_pkg::ST_EMPTY;
                        state_next  = S_IDLE;
                    end
                end else begin
                    if (can_emit) begin
                        emit      = 1'b1;
                        emit_data = ram_rdata;
                        emit_last = (OW'(pos_reg) + OW'(1)) == occ_reg;
                    end
                    if (issue) begin
                        ram_re    = 1'b1;
                        pos_next  = idx_reg[AW-1:0];
                        idx_next  = idx_reg + OW'(1);
                        pend_next = 1'b1;
                    end else begin
                        pend_next = pend_reg && !can_emit;
                    end
                    if (!more && (!pend_reg || can_emit)) begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            pend_reg  <= pend_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        key_reg  <= key_next;
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        if (emit) begin
            m_status_reg <= emit_status;
            m_data_reg   <= emit_data;
            m_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== src/kfsd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module kfsd_ram #(
    parameter int WIDTH = 112,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable; read data holds until the next read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== dv/keyed_fifo_search_delete_checker.sv =====
// Channel monitor for the keyed queue: predicts every result item and compares it on arrival.
module keyed_fifo_search_delete_checker #(
    parameter int DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,   // [55:0] key_hi, [111:56] key_lo
    input  logic [1:0]   s_tuser,   // [1:0] func
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,   // [55:0] entry_hi, [111:56] entry_lo
    input  logic [1:0]   m_tuser,   // [1:0] status
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending,
    output int           results_seen
);

    typedef struct {
        kfsd_pkg::status_t status;
        logic [55:0]       ent_hi;
        logic [55:0]       ent_lo;
        logic              last;
    } queue_result_t;

    // Predicted queue contents and the results still owed by the block
    kfsd_pkg::key_t slots [DEPTH];
    int             held;
    queue_result_t  owed_results [$];
    int             mismatches;
    int             seen;

    initial begin
        held       = 0;
        mismatches = 0;
        seen       = 0;
    end

    // Cut a key at its first zero character and clear everything after it
    function automatic kfsd_pkg::key_t trim_key(kfsd_pkg::key_t raw);
        kfsd_pkg::key_t t;
        bit             stop;
        int             pos;
        t    = '0;
        stop = 1'b0;
        for (int i = 0; i < kfsd_pkg::KEY_BYTES; i++) begin
            pos = (i < kfsd_pkg::HALF_CHARS)
                ? 8 * (kfsd_pkg::HALF_CHARS - 1 - i)
                : kfsd_pkg::HALF_W + 8 * (kfsd_pkg::KEY_BYTES - 1 - i);
            if (i >= kfsd_pkg::KEY_CHARS || raw[pos +: 8] == 8'd0) begin
                stop = 1'b1;
            end
            if (!stop) begin
                t[pos +: 8] = raw[pos +: 8];
            end
        end
        return t;
    endfunction

    function automatic void owe_result(kfsd_pkg::status_t st, kfsd_pkg::key_t k, logic last);
        queue_result_t r;
        r.status = st;
        r.ent_hi = k[55:0];
        r.ent_lo = k[111:56];
        r.last   = last;
        owed_results.push_back(r);
    endfunction

    // Apply one request to the predicted queue and record the results it owes
    function automatic void predict_request(kfsd_pkg::func_t op, kfsd_pkg::key_t raw);
        kfsd_pkg::key_t k;
        int             hit;
        k   = trim_key(raw);
        hit = -1;
        for (int i = 0; i < held; i++) begin
            if (hit < 0 && slots[i] == k) begin
                hit = i;
            end
        end
        case (op)
            kfsd_pkg::FN_INSERT: begin
                if (held >= DEPTH) begin
                    owe_result(kfsd_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    slots[held] = k;
                    held++;
                    owe_result(kfsd_pkg::ST_OK, '0, 1'b1);
                end
            end
            kfsd_pkg::FN_DELETE: begin
                if (hit < 0) begin
                    owe_result(kfsd_pkg::ST_NOTFOUND, '0, 1'b1);
                end else begin
                    owe_result(kfsd_pkg::ST_OK, slots[hit], 1'b1);
                    for (int i = hit; i < held - 1; i++) begin
                        slots[i] = slots[i + 1];
                    end
                    held--;
                end
            end
            kfsd_pkg::FN_SEARCH: begin
                if (hit < 0) begin
                    owe_result(kfsd_pkg::ST_NOTFOUND, '0, 1'b1);
                end else begin
                    owe_result(kfsd_pkg::ST_OK, slots[hit], 1'b1);
                end
            end
            default: begin
                if (held == 0) begin
                    owe_result(kfsd_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < held; i++) begin
                        owe_result(kfsd_pkg::ST_OK, slots[i], (i == held - 1));
                    end
                end
            end
        endcase
    endfunction

    // Compare one delivered item with the oldest owed result
    function automatic void check_result(kfsd_pkg::status_t st, logic [111:0] d, logic last);
        queue_result_t r;
        seen++;
        if (owed_results.size() == 0) begin
            if (mismatches < 10) begin
                $display("unexpected result item: status %0d entry %h_%h last %0b",
                         st, d[55:0], d[111:56], last);
            end
            mismatches++;
        end else begin
            r = owed_results.pop_front();
            if (r.status !== st || r.ent_hi !== d[55:0] || r.ent_lo !== d[111:56]
                || r.last !== last) begin
                if (mismatches < 10) begin
                    $display(
                        "result %0d mismatch: status %0d/%0d hi %h/%h lo %h/%h last %0b/%0b",
                        seen, r.status, st, r.ent_hi, d[55:0], r.ent_lo, d[111:56],
                        r.last, last);
                end
                mismatches++;
            end
        end
    endfunction

    // Watch both channels; take requests first so a same-edge result would still find them
    always @(posedge aclk) begin
        if (!aresetn) begin
            held = 0;
            owed_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predict_request(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_result(m_tuser, m_tdata, m_tlast);
            end
        end
        fail_count   <= mismatches;
        pending      <= owed_results.size();
        results_seen <= seen;
    end

endmodule

// ===== dv/keyed_fifo_search_delete_tb.sv =====
// Stimulus and verdict for the keyed queue: drives requests, paces results, reports the outcome.
module keyed_fifo_search_delete_tb;

    localparam int DEPTH       = 16;
    localparam int POOL        = 8;
    localparam int RAND_ITEMS  = 104;
    localparam int STALL_LEN   = 250;
    localparam int DRAIN       = 60;
    localparam int CYCLE_LIMIT = 300000;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata  = '0;   // [55:0] key_hi, [111:56] key_lo
    logic [1:0]   s_tuser  = '0;   // [1:0] func
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;         // [55:0] entry_hi, [111:56] entry_lo
    logic [1:0]   m_tuser;         // [1:0] status
    logic         m_tlast;

    int fail_count;
    int pending;
    int results_seen;

    int             cycles        = 0;
    bit             calm          = 1'b0;
    bit             stall_request = 1'b0;
    int             stall_left    = 0;
    int             op_count [4]  = '{0, 0, 0, 0};
    kfsd_pkg::key_t pool_chars [POOL];
    int             pool_len [POOL];

    keyed_fifo_search_delete #(
        .DEPTH(DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    keyed_fifo_search_delete_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .results_seen(results_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Bit position of character i in the packed key
    function automatic int char_lsb(int i);
        return (i < kfsd_pkg::HALF_CHARS)
            ? 8 * (kfsd_pkg::HALF_CHARS - 1 - i)
            : kfsd_pkg::HALF_W + 8 * (kfsd_pkg::KEY_BYTES - 1 - i);
    endfunction

    // Pool key with its terminator in place (none at full length) and fresh garbage after it
    function automatic kfsd_pkg::key_t pooled_key(int idx);
        kfsd_pkg::key_t k;
        k = pool_chars[idx];
        for (int i = 0; i < kfsd_pkg::KEY_BYTES; i++) begin
            if (i == pool_len[idx]) begin
                k[char_lsb(i) +: 8] = 8'd0;
            end else if (i > pool_len[idx]) begin
                k[char_lsb(i) +: 8] = 8'($urandom);
            end
        end
        return k;
    endfunction

    function automatic kfsd_pkg::key_t random_key();
        kfsd_pkg::key_t k;
        k[31:0]   = $urandom;
        k[63:32]  = $urandom;
        k[95:64]  = $urandom;
        k[111:96] = 16'($urandom);
        return k;
    endfunction

    // Alternate insert-heavy and delete-heavy stretches so the queue fills and drains
    function automatic kfsd_pkg::func_t pick_op(int j);
        int r;
        r = $urandom_range(99);
        if ((j / 30) % 2 == 0) begin
            if (r < 55) return kfsd_pkg::FN_INSERT;
            if (r < 70) return kfsd_pkg::FN_DELETE;
            if (r < 88) return kfsd_pkg::FN_SEARCH;
            return kfsd_pkg::FN_DUMP;
        end
        if (r < 20) return kfsd_pkg::FN_INSERT;
        if (r < 60) return kfsd_pkg::FN_DELETE;
        if (r < 85) return kfsd_pkg::FN_SEARCH;
        return kfsd_pkg::FN_DUMP;
    endfunction

    // Offer one request item, idling first at random, and hold it until accepted
    task automatic offer_request(input kfsd_pkg::func_t op, input kfsd_pkg::key_t key);
        if (!calm) begin
            while ($urandom_range(99) < 37) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        op_count[op]++;
    endtask

    // Pace the result side; a requested stall holds tready low for a long stretch
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (stall_request) begin
                stall_request = 1'b0;
                stall_left    = STALL_LEN - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 37);
            end
        end
    end

    // Abort on a hung run
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        // Build the key pool; pin lengths for two-char, full-length, empty and half-split keys
        for (int p = 0; p < POOL; p++) begin
            for (int i = 0; i < kfsd_pkg::KEY_BYTES; i++) begin
                pool_chars[p][char_lsb(i) +: 8] = 8'($urandom_range(255, 1));
            end
            pool_len[p] = $urandom_range(14, 0);
        end
        pool_len[0] = 2;
        pool_len[1] = 14;
        pool_len[2] = 0;
        pool_len[3] = 7;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty queue cases
        offer_request(kfsd_pkg::FN_DUMP, '0);
        offer_request(kfsd_pkg::FN_SEARCH, pooled_key(0));
        offer_request(kfsd_pkg::FN_DELETE, pooled_key(0));
        // Extreme keys, the empty string, and a key cut short by a zero character
        offer_request(kfsd_pkg::FN_INSERT, '1);
        offer_request(kfsd_pkg::FN_INSERT, pooled_key(2));
        offer_request(kfsd_pkg::FN_INSERT, pooled_key(0));
        offer_request(kfsd_pkg::FN_SEARCH, pooled_key(0));
        offer_request(kfsd_pkg::FN_SEARCH, '0);
        // Duplicates: only the first copy goes on delete
        offer_request(kfsd_pkg::FN_INSERT, pooled_key(3));
        offer_request(kfsd_pkg::FN_INSERT, pooled_key(1));
        offer_request(kfsd_pkg::FN_INSERT, pooled_key(3));
        offer_request(kfsd_pkg::FN_DELETE, pooled_key(3));
        // Fill to capacity, overflow, dump the full queue, remove the head
        for (int i = 0; i < DEPTH - 5; i++) begin
            offer_request(kfsd_pkg::FN_INSERT, random_key());
        end
        offer_request(kfsd_pkg::FN_INSERT, random_key());
        offer_request(kfsd_pkg::FN_DUMP, random_key());
        offer_request(kfsd_pkg::FN_DELETE, '1);

        // Random traffic with one long result stall and one calm stretch
        for (int j = 0; j < RAND_ITEMS; j++) begin
            if (j == 20) begin
                stall_request = 1'b1;
            end
            calm = (j >= 60 && j < 100);
            if ($urandom_range(99) < 75) begin
                offer_request(pick_op(j), pooled_key($urandom_range(POOL - 1)));
            end else begin
                offer_request(pick_op(j), random_key());
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Drain every owed result, then let the block settle
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN) @(posedge aclk);

        $display("Sent %0d items (%0d ins, %0d del, %0d srch, %0d dump); %0d results checked.",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[kfsd_pkg::FN_INSERT], op_count[kfsd_pkg::FN_DELETE],
                 op_count[kfsd_pkg::FN_SEARCH], op_count[kfsd_pkg::FN_DUMP], results_seen);
        $display("Covered empty/full queue, duplicate and zero-cut keys, a %0d-cycle output stall.",
                 STALL_LEN);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
